/* rtl/numeric_literal_scanner_top_assert.svh */
// assertion macros for the numeric literal scanner
`ifndef NUMERIC_LITERAL_SCANNER_TOP_ASSERT_SVH
`define NUMERIC_LITERAL_SCANNER_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
// checked only outside reset
`define NLS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked at every edge, reset included
`define NLS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define NLS_ASSERT(label, clk, rst, prop, msg)
`define NLS_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

/* rtl/nls_pkg.sv */
// shared types, codes and character helpers of the numeric literal scanner
package nls_pkg;

  localparam int LENGTH_BITS_DEF = 8;

  localparam logic [15:0] CHAR_ZERO = 16'h0030;
  localparam logic [15:0] CHAR_NINE = 16'h0039;
  localparam logic [15:0] CHAR_DOT  = 16'h002E;
  localparam logic [15:0] CHAR_X    = 16'h0078;
  localparam logic [15:0] CHAR_A    = 16'h0061;
  localparam logic [15:0] CHAR_F    = 16'h0066;
  localparam logic [15:0] CASE_BIT  = 16'h0020;
  localparam logic [11:0] OCTET_MAX = 12'd255;

  localparam logic [1:0] FORM_DEC  = 2'd0;
  localparam logic [1:0] FORM_HEX  = 2'd1;
  localparam logic [1:0] FORM_QUAD = 2'd2;
  localparam logic [1:0] FORM_NONE = 2'd3;

  typedef struct packed {
    logic        token_start;
    logic [15:0] char_code;
  } item_t;

  typedef struct packed {
    logic [63:0] number_value;
    logic [7:0]  chars_consumed;
    logic        found;
    logic [1:0]  literal_form;
  } result_t;

  function automatic logic is_dec(input logic [15:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  function automatic logic is_hex(input logic [15:0] c);
    logic [15:0] l;
    l = c | CASE_BIT;
    return is_dec(c) || ((l >= CHAR_A) && (l <= CHAR_F));
  endfunction

  // letters a..f have low nibble 1..6, value is nibble plus nine
  function automatic logic [3:0] hex_val(input logic [15:0] c);
    return is_dec(c) ? c[3:0] : c[3:0] + 4'd9;
  endfunction

endpackage

/* rtl/nls_in_stage.sv */
// input register holding one character request
module nls_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  nls_pkg::item_t    item,
  input  logic              take,
  output logic              full,
  output nls_pkg::item_t    item_q
);

  assign item_ready = !full || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (item_valid && item_ready) begin
      full <= 1'b1;
    end else if (take) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      item_q <= item;
    end
  end

endmodule

/* rtl/nls_core.sv */
// scan state and the per-character step logic
module nls_core #(
  parameter int LENGTH_BITS = nls_pkg::LENGTH_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  nls_pkg::item_t    item_q,
  output logic              emit,
  output nls_pkg::result_t  res
);

  localparam logic [2:0] PH_IDLE      = 3'd0;
  localparam logic [2:0] PH_ZERO      = 3'd1;
  localparam logic [2:0] PH_HEX_FIRST = 3'd2;
  localparam logic [2:0] PH_HEX_RUN   = 3'd3;
  localparam logic [2:0] PH_BOTH      = 3'd4;
  localparam logic [2:0] PH_QUAD      = 3'd5;
  localparam logic [2:0] PH_DEC       = 3'd6;

  logic [2:0]             phase, phase_next;
  logic [63:0]            acc, acc_next;
  logic [31:0]            quad, quad_next;
  logic [11:0]            octet, octet_next;
  logic [2:0]             digits, digits_next;
  logic [1:0]             oct_idx, oct_idx_next;
  logic [LENGTH_BITS-1:0] first_len, first_len_next;
  logic [LENGTH_BITS-1:0] total_len, total_len_next;

  always_comb begin
    logic [15:0]            c;
    logic                   dec;
    logic                   hex;
    logic [3:0]             d;
    logic [11:0]            x;
    logic [63:0]            acc10;
    logic [2:0]             digits_inc;
    logic [31:0]            quad_shift;
    logic [LENGTH_BITS-1:0] first_inc;
    logic [LENGTH_BITS-1:0] total_inc;
    logic                   is_x;
    logic                   do_both;
    logic                   dec_out;

    c          = item_q.char_code;
    dec        = nls_pkg::is_dec(c);
    hex        = nls_pkg::is_hex(c);
    d          = c[3:0];
    x          = 12'(octet << 3) + 12'(octet << 1) + 12'(d);
    acc10      = (acc << 3) + (acc << 1) + 64'(d);
    digits_inc = digits + 3'd1;
    quad_shift = {quad[23:0], octet[7:0]};
    first_inc  = (first_len == '1) ? first_len : first_len + LENGTH_BITS'(1);
    total_inc  = (total_len == '1) ? total_len : total_len + LENGTH_BITS'(1);
    is_x       = (c | nls_pkg::CASE_BIT) == nls_pkg::CHAR_X;
    do_both    = 1'b0;
    dec_out    = 1'b0;

    phase_next     = phase;
    acc_next       = acc;
    quad_next      = quad;
    octet_next     = octet;
    digits_next    = digits;
    oct_idx_next   = oct_idx;
    first_len_next = first_len;
    total_len_next = total_len;
    emit           = 1'b0;
    res            = '0;

    if (go) begin
      if (item_q.token_start) begin
        quad_next    = '0;
        oct_idx_next = '0;
        if (!dec) begin
          acc_next       = '0;
          octet_next     = '0;
          digits_next    = '0;
          first_len_next = '0;
          total_len_next = '0;
          emit           = 1'b1;
          res.literal_form = nls_pkg::FORM_NONE;
          phase_next     = PH_IDLE;
        end else begin
          acc_next       = 64'(d);
          octet_next     = 12'(d);
          digits_next    = 3'd1;
          first_len_next = LENGTH_BITS'(1);
          total_len_next = LENGTH_BITS'(1);
          phase_next     = (c == nls_pkg::CHAR_ZERO) ? PH_ZERO : PH_BOTH;
        end
      end else begin
        unique case (phase)
          PH_ZERO: begin
            if (is_x) begin
              acc_next       = '0;
              total_len_next = total_inc;
              phase_next     = PH_HEX_FIRST;
            end else begin
              phase_next = PH_BOTH;
              do_both    = 1'b1;
            end
          end
          PH_HEX_FIRST: begin
            if (!hex) begin
              emit               = 1'b1;
              res.chars_consumed = 8'(total_len);
              res.literal_form   = nls_pkg::FORM_NONE;
              phase_next         = PH_IDLE;
            end else begin
              acc_next       = 64'(nls_pkg::hex_val(c));
              total_len_next = total_inc;
              phase_next     = PH_HEX_RUN;
            end
          end
          PH_HEX_RUN: begin
            if (!hex) begin
              emit               = 1'b1;
              res.number_value   = acc;
              res.chars_consumed = 8'(total_len);
              res.found          = 1'b1;
              res.literal_form   = nls_pkg::FORM_HEX;
              phase_next         = PH_IDLE;
            end else begin
              acc_next       = {acc[59:0], nls_pkg::hex_val(c)};
              total_len_next = total_inc;
            end
          end
          PH_BOTH: begin
            do_both = 1'b1;
          end
          PH_QUAD: begin
            if (dec) begin
              digits_next    = digits_inc;
              total_len_next = total_inc;
              if (digits_inc > 3'd3 || x > nls_pkg::OCTET_MAX) begin
                dec_out = 1'b1;
              end else begin
                octet_next = x;
              end
            end else if (digits == 3'd0) begin
              dec_out = 1'b1;
            end else begin
              quad_next = quad_shift;
              if (oct_idx == 2'd3) begin
                emit               = 1'b1;
                res.number_value   = 64'(quad_shift);
                res.chars_consumed = 8'(total_len);
                res.found          = 1'b1;
                res.literal_form   = nls_pkg::FORM_QUAD;
                phase_next         = PH_IDLE;
              end else if (c == nls_pkg::CHAR_DOT) begin
                oct_idx_next   = oct_idx + 2'd1;
                digits_next    = '0;
                octet_next     = '0;
                total_len_next = total_inc;
              end else begin
                dec_out = 1'b1;
              end
            end
          end
          PH_DEC: begin
            if (!dec) begin
              dec_out = 1'b1;
            end else begin
              acc_next       = acc10;
              first_len_next = first_inc;
            end
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase

        // digit run shared by the undecided phases
        if (do_both) begin
          if (dec) begin
            acc_next       = acc10;
            first_len_next = first_inc;
            total_len_next = total_inc;
            digits_next    = digits_inc;
            if (digits_inc > 3'd3 || x > nls_pkg::OCTET_MAX) begin
              phase_next = PH_DEC;
            end else begin
              octet_next = x;
            end
          end else if (c == nls_pkg::CHAR_DOT) begin
            quad_next      = 32'(octet);
            oct_idx_next   = 2'd1;
            digits_next    = '0;
            octet_next     = '0;
            total_len_next = total_inc;
            phase_next     = PH_QUAD;
          end else begin
            dec_out = 1'b1;
          end
        end

        // fall back to the first decimal run
        if (dec_out) begin
          emit               = 1'b1;
          res.number_value   = acc;
          res.chars_consumed = 8'(first_len);
          res.found          = 1'b1;
          res.literal_form   = nls_pkg::FORM_DEC;
          phase_next         = PH_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      acc       <= '0;
      quad      <= '0;
      octet     <= '0;
      digits    <= '0;
      oct_idx   <= '0;
      first_len <= '0;
      total_len <= '0;
    end else begin
      phase     <= phase_next;
      acc       <= acc_next;
      quad      <= quad_next;
      octet     <= octet_next;
      digits    <= digits_next;
      oct_idx   <= oct_idx_next;
      first_len <= first_len_next;
      total_len <= total_len_next;
    end
  end

endmodule

/* rtl/nls_out_stage.sv */
// result register towards the consumer
module nls_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  nls_pkg::result_t  load_data,
  output logic              space,
  output logic              result_valid,
  input  logic              result_ready,
  output nls_pkg::result_t  result
);

  assign space = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= load_data;
    end
  end

endmodule

/* rtl/numeric_literal_scanner_top.sv */
// top level of the numeric literal scanner
//
//   channel  direction  handshake                    payload
//   item     in         item_valid / item_ready      nls_pkg::item_t
//   result   out        result_valid / result_ready  nls_pkg::result_t
//
// one character per cycle while the result is not stalled, set by the single step of the scan logic
// a character waits in the input register, the scan step on it is combinational, its result goes to the result register
// synchronous reset puts the scanner in idle, no clearing pass
// a stalled result holds the scan, the input register still takes one more request
`include "numeric_literal_scanner_top_assert.svh"

module numeric_literal_scanner_top #(
  parameter int LENGTH_BITS = nls_pkg::LENGTH_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  nls_pkg::item_t    item,
  output logic              result_valid,
  input  logic              result_ready,
  output nls_pkg::result_t  result
);

  logic             in_full;     // a request waits in the input register
  nls_pkg::item_t   item_q;      // that request
  logic             space;       // result register free at the next edge
  logic             go;          // step the scan on the held request
  logic             emit;        // this step decides a literal
  nls_pkg::result_t step_res;    // the decided result

  // a step only runs when its result, if any, has somewhere to go
  assign go = in_full && space;

  nls_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .take       (go),
    .full       (in_full),
    .item_q     (item_q)
  );

  nls_core #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .go     (go),
    .item_q (item_q),
    .emit   (emit),
    .res    (step_res)
  );

  nls_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (go && emit),
    .load_data    (step_res),
    .space        (space),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  // a failed scan never reports a value
  `NLS_ASSERT(a_fail_zero, clk, rst,
    result_valid && !result.found |-> result.number_value == 64'd0,
    "failed scan with nonzero value")
  // found and the none form go together
  `NLS_ASSERT(a_found_form, clk, rst,
    result_valid |-> (result.found == (result.literal_form != nls_pkg::FORM_NONE)),
    "found flag disagrees with form")
  // a full input register behind a stalled result refuses new requests
  `NLS_ASSERT(a_stall_block, clk, rst,
    in_full && result_valid && !result_ready |-> !item_ready,
    "request taken while stalled")
  // a decided step always shows its result next cycle
  `NLS_ASSERT(a_emit_shows, clk, rst, go && emit |=> result_valid, "decided result lost")

endmodule
